>>> rtl/core/pld_pkg.sv
`default_nettype none
package pld_pkg;

  localparam int NUM_LABELS = 2;
  localparam int LABEL_W    = 1;
  localparam int POS_W      = 15;
  localparam int DIFF_W     = POS_W + 1;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 32;
  localparam int DIST_W     = 16;
  localparam int SPEED_W    = 32;
  localparam int US_W       = 20;
  localparam int MUL_W      = DIST_W + US_W;
  localparam int ROOT_REM_W = DIST_W + 2;

  localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

  localparam int SQ_STEPS   = 3;
  localparam int ROOT_STEPS = DIST_W;
  localparam int DIV_STEPS  = MUL_W;
  localparam int CNT_W      = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQ,
    S_ROOT,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       start;
    logic       sq_step;
    logic [1:0] sel;
    logic       root_step;
    logic       mul;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/pld_ctrl.sv
`default_nettype none
module pld_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  pld_pkg::status_t status,
  output pld_pkg::cmd_t  cmd
);
  import pld_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic last_sq, last_root, last_div;

  assign last_sq   = (cnt == CNT_W'(SQ_STEPS - 1));
  assign last_root = (cnt == CNT_W'(ROOT_STEPS - 1));
  assign last_div  = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        cnt_next   = '0;
        state_next = status.hit ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cnt_next = cnt + 1'b1;
        if (last_sq) begin
          cnt_next   = '0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        cnt_next = cnt + 1'b1;
        if (last_root) begin
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (last_div) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sel       = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_CHECK: cmd.start     = status.hit;
      S_SQ:    cmd.sq_step   = 1'b1;
      S_ROOT:  cmd.root_step = 1'b1;
      S_MUL:   cmd.mul       = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_DONE:  cmd.load_out  = status.out_free;
      default: in_ready      = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pld_datapath.sv
`default_nettype none
module pld_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  pld_pkg::cmd_t                      cmd,
  output pld_pkg::status_t                   status,
  input  wire        [pld_pkg::LABEL_W-1:0]  label,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_x,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_y,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_z,
  input  wire        [pld_pkg::TIME_W-1:0]   time_us,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic       [pld_pkg::LABEL_W-1:0]  out_label,
  output logic       [pld_pkg::DIST_W-1:0]   distance_mm,
  output logic       [pld_pkg::SPEED_W-1:0]  speed_mm_per_s
);
  import pld_pkg::*;

  logic                     seen [NUM_LABELS];
  logic signed [POS_W-1:0]  last_x [NUM_LABELS];
  logic signed [POS_W-1:0]  last_y [NUM_LABELS];
  logic signed [POS_W-1:0]  last_z [NUM_LABELS];
  logic [TIME_W-1:0]        last_time [NUM_LABELS];

  logic                     label_ok;
  logic [LABEL_W-1:0]       cap_label;
  logic                     hit;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [TIME_W-1:0]        dt;
  logic [SUM_W-1:0]         acc;
  logic [ROOT_REM_W-1:0]    rem_s;
  logic [DIST_W-1:0]        root;
  logic [MUL_W-1:0]         num;
  logic [TIME_W-1:0]        rem_d;

  logic signed [DIFF_W-1:0] d_sel;
  logic [DIFF_W-1:0]        d_abs;
  logic [2*POS_W-1:0]       d_sq;
  logic [ROOT_REM_W:0]      rem_sh, trial;
  logic                     root_ge;
  logic [TIME_W:0]          div_sh;
  logic                     div_ge;

  assign label_ok = (int'(label) < NUM_LABELS);
  assign status   = '{hit: hit, out_free: (!out_valid || out_ready)};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LABELS; i++) seen[i] <= 1'b0;
    end else if (cmd.capture && label_ok) begin
      seen[label] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && label_ok) begin
      last_x[label]    <= pos_x;
      last_y[label]    <= pos_y;
      last_z[label]    <= pos_z;
      last_time[label] <= time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.capture) begin
      hit <= label_ok && seen[label];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_label <= label;
      dx <= DIFF_W'(pos_x) - DIFF_W'(last_x[label]);
      dy <= DIFF_W'(pos_y) - DIFF_W'(last_y[label]);
      dz <= DIFF_W'(pos_z) - DIFF_W'(last_z[label]);
      dt <= time_us - last_time[label];
    end
  end

  always_comb begin
    case (cmd.sel)
      2'd0:    d_sel = dx;
      2'd1:    d_sel = dy;
      default: d_sel = dz;
    endcase
    d_abs = d_sel[DIFF_W-1] ? DIFF_W'(-d_sel) : DIFF_W'(d_sel);
    d_sq  = d_abs[POS_W-1:0] * d_abs[POS_W-1:0];
  end

  assign rem_sh  = {rem_s[ROOT_REM_W-2:0], acc[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign root_ge = (rem_sh >= trial);

  assign div_sh = {rem_d, num[MUL_W-1]};
  assign div_ge = (div_sh >= {1'b0, dt});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc   <= '0;
      rem_s <= '0;
      root  <= '0;
    end else if (cmd.sq_step) begin
      acc <= acc + SUM_W'(d_sq);
    end else if (cmd.root_step) begin
      rem_s <= root_ge ? ROOT_REM_W'(rem_sh - trial) : ROOT_REM_W'(rem_sh);
      root  <= {root[DIST_W-2:0], root_ge};
      acc   <= acc << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num   <= MUL_W'(root * US_PER_S);
      rem_d <= '0;
    end else if (cmd.div_step) begin
      rem_d <= div_ge ? TIME_W'(div_sh - {1'b0, dt}) : TIME_W'(div_sh);
      num   <= {num[MUL_W-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_label      <= cap_label;
      distance_mm    <= root;
      speed_mm_per_s <= (|num[MUL_W-1:SPEED_W]) ? '1 : num[SPEED_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/per_label_displacement_speed.sv
// channel  signals                                     handshake
// in       label pos_x pos_y pos_z time_us             in_valid  / in_ready
// out      out_label distance_mm speed_mm_per_s        out_valid / out_ready
//
// a repeat sighting goes from request to result through 1 capture, 1 check,
// 3 squaring steps on one 15x15 multiplier, 16 root steps, 1 scaling multiply,
// 36 restoring divide steps and 1 output load; a first sighting gives no result
// the result sits in an output register, so the next request is taken while it waits
// rst is synchronous; it clears the seen marks and empties the output register
`default_nettype none
module per_label_displacement_speed (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire        [pld_pkg::LABEL_W-1:0]  label,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_x,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_y,
  input  wire signed [pld_pkg::POS_W-1:0]    pos_z,
  input  wire        [pld_pkg::TIME_W-1:0]   time_us,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic       [pld_pkg::LABEL_W-1:0]  out_label,
  output logic       [pld_pkg::DIST_W-1:0]   distance_mm,
  output logic       [pld_pkg::SPEED_W-1:0]  speed_mm_per_s
);
  import pld_pkg::*;

  cmd_t    cmd;
  status_t status;

  pld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pld_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .label          (label),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .time_us        (time_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_label      (out_label),
    .distance_mm    (distance_mm),
    .speed_mm_per_s (speed_mm_per_s)
  );

endmodule
`default_nettype wire

>>> rtl/core/pld_checker.sv
`default_nettype none
module pld_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [pld_pkg::DIST_W-1:0]         distance_mm,
  input wire [pld_pkg::SPEED_W-1:0]        speed_mm_per_s
);
  import pld_pkg::*;

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // no motion means zero speed, unless the time difference was zero
  a_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && distance_mm == '0 |->
      speed_mm_per_s == '0 || speed_mm_per_s == '1)
    else $error("speed without displacement");

endmodule

bind per_label_displacement_speed pld_checker u_pld_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .distance_mm    (distance_mm),
  .speed_mm_per_s (speed_mm_per_s)
);
`default_nettype wire
